>>> rtl/fsba_pkg.sv
// Package of shared types and constants for the fit-strategy block allocator.
package fsba_pkg;

    localparam int DEF_NUM_BLOCKS = 16;
    localparam int DEF_SIZE_WIDTH = 16;

    typedef logic [3:0] blk_idx_t;

    typedef enum logic [1:0] {
        STRAT_FIRST = 2'd0,
        STRAT_BEST  = 2'd1,
        STRAT_WORST = 2'd2,
        STRAT_NONE  = 2'd3
    } strategy_t;

    typedef enum logic {
        REG_STRATEGY      = 1'b0,
        REG_BLOCKS_IN_USE = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_WRITE = 2'd2
    } state_t;

    typedef struct packed {
        logic        operation;
        blk_idx_t    block_index;
        logic [15:0] block_size;
        logic [15:0] request_size;
    } in_item_t;

    typedef struct packed {
        logic     granted;
        blk_idx_t granted_block;
    } out_item_t;

endpackage

>>> rtl/fit_strategy_block_allocator_unit.sv
// Top level of the fit-strategy block allocator: control, configuration and the cell row.
//
// Channel | Handshake                  | Payload
// input   | start, busy                | item (fsba_pkg::in_item_t)
// result  | result_valid (one cycle)   | result (fsba_pkg::out_item_t)
// config  | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// A load gives no result.
// A request passes the scan state, in which the candidate moves through the row of cells,
// one cell per cycle, and then the write-back state; the result strobe is registered from
// the write-back state. A new item can be accepted while the strobe is shown.
// Reset clears all block sizes to zero, strategy to first fit and blocks in use to 16.
// The receiver cannot stall the result.
module fit_strategy_block_allocator_unit #(
    parameter int NUM_BLOCKS = fsba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_WIDTH = fsba_pkg::DEF_SIZE_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fsba_pkg::in_item_t  item,
    output logic                result_valid,
    output fsba_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  fsba_pkg::cfg_reg_t  cfg_index,
    input  logic [4:0]          cfg_data
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    fsba_pkg::state_t      state_reg;
    fsba_pkg::state_t      state_next;
    logic [IDX_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      cnt_next;
    logic [SIZE_WIDTH-1:0] req_reg;
    fsba_pkg::strategy_t   strategy_reg;
    logic [4:0]            biu_reg;
    logic                  done_reg;
    logic                  done_next;
    fsba_pkg::out_item_t   res_reg;
    fsba_pkg::out_item_t   res_next;

    logic                  accept;
    logic                  load_ok;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [SIZE_WIDTH-1:0] wr_value;

    logic                  cand_found [NUM_BLOCKS+1];
    logic [IDX_W-1:0]      cand_idx   [NUM_BLOCKS+1];
    logic [SIZE_WIDTH-1:0] cand_val   [NUM_BLOCKS+1];
    logic [NUM_BLOCKS-1:0] active;

    assign cand_found[0] = 1'b0;
    assign cand_idx[0]   = '0;
    assign cand_val[0]   = '0;

    assign accept  = start && !busy;
    assign load_ok = 32'(item.block_index) < NUM_BLOCKS;

    for (genvar i = 0; i < NUM_BLOCKS; i++)
    begin : g_cell
        assign active[i] = 32'(i) < 32'(biu_reg);

        fsba_cell #(
            .NUM_BLOCKS (NUM_BLOCKS),
            .SIZE_WIDTH (SIZE_WIDTH),
            .CELL_IDX   (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .strategy       (strategy_reg),
            .active         (active[i]),
            .req_size       (req_reg),
            .wr_en          (wr_en),
            .wr_idx         (wr_idx),
            .wr_value       (wr_value),
            .cand_found_in  (cand_found[i]),
            .cand_idx_in    (cand_idx[i]),
            .cand_val_in    (cand_val[i]),
            .cand_found_out (cand_found[i+1]),
            .cand_idx_out   (cand_idx[i+1]),
            .cand_val_out   (cand_val[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            fsba_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && item.operation == fsba_pkg::OP_REQUEST)
                begin
                    state_next = fsba_pkg::ST_SCAN;
                end
            end
            fsba_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(NUM_BLOCKS - 1))
                begin
                    state_next = fsba_pkg::ST_WRITE;
                end
            end
            fsba_pkg::ST_WRITE:
            begin
                state_next = fsba_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fsba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = 1'b0;
        wr_en     = 1'b0;
        wr_idx    = IDX_W'(item.block_index);
        wr_value  = SIZE_WIDTH'(item.block_size);
        done_next = 1'b0;
        res_next  = '0;
        unique case (state_reg)
            fsba_pkg::ST_IDLE:
            begin
                wr_en = start && item.operation == fsba_pkg::OP_LOAD && load_ok;
            end
            fsba_pkg::ST_SCAN:
            begin
                busy = 1'b1;
            end
            fsba_pkg::ST_WRITE:
            begin
                busy      = 1'b1;
                wr_en     = cand_found[NUM_BLOCKS];
                wr_idx    = cand_idx[NUM_BLOCKS];
                wr_value  = cand_val[NUM_BLOCKS] - req_reg;
                done_next = 1'b1;
                res_next.granted = cand_found[NUM_BLOCKS];
                if (cand_found[NUM_BLOCKS])
                begin
                    res_next.granted_block = fsba_pkg::blk_idx_t'(cand_idx[NUM_BLOCKS]);
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fsba_pkg::ST_IDLE;
            cnt_reg      <= '0;
            strategy_reg <= fsba_pkg::STRAT_FIRST;
            biu_reg      <= 5'd16;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    fsba_pkg::REG_STRATEGY:
                        strategy_reg <= fsba_pkg::strategy_t'(cfg_data[1:0]);
                    fsba_pkg::REG_BLOCKS_IN_USE:
                        biu_reg <= cfg_data;
                    default:
                        biu_reg <= biu_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= SIZE_WIDTH'(item.request_size);
        end
        res_reg <= res_next;
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = done_reg;
    assign result       = res_reg;

    a_strobe_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == fsba_pkg::ST_WRITE))
        else $error("Result strobe without a write-back cycle.");

    a_denied_zero_block: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.granted) |-> result.granted_block == '0)
        else $error("Denied request reports a nonzero block.");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("Block became busy without an accepted item.");

    a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fsba_pkg::ST_SCAN && cnt_reg == IDX_W'(NUM_BLOCKS - 1))
        |=> state_reg == fsba_pkg::ST_WRITE)
        else $error("Scan did not end after the last cell.");

endmodule

>>> rtl/fsba_cell.sv
// One allocator cell: holds a block's remaining size and refines the passing candidate.
module fsba_cell #(
    parameter int NUM_BLOCKS = fsba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_WIDTH = fsba_pkg::DEF_SIZE_WIDTH,
    parameter int CELL_IDX   = 0,
    localparam int IDX_W     = $clog2(NUM_BLOCKS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fsba_pkg::strategy_t   strategy,
    input  logic                  active,
    input  logic [SIZE_WIDTH-1:0] req_size,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [SIZE_WIDTH-1:0] wr_value,
    input  logic                  cand_found_in,
    input  logic [IDX_W-1:0]      cand_idx_in,
    input  logic [SIZE_WIDTH-1:0] cand_val_in,
    output logic                  cand_found_out,
    output logic [IDX_W-1:0]      cand_idx_out,
    output logic [SIZE_WIDTH-1:0] cand_val_out
);

    logic [SIZE_WIDTH-1:0] rem_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [SIZE_WIDTH-1:0] val_reg;
    logic                  fits;
    logic                  take;

    always_comb
    begin
        fits = active && (rem_reg >= req_size);
        unique case (strategy)
            fsba_pkg::STRAT_FIRST: take = fits && !cand_found_in;
            fsba_pkg::STRAT_BEST:  take = fits && (!cand_found_in || rem_reg < cand_val_in);
            fsba_pkg::STRAT_WORST: take = fits && (!cand_found_in || rem_reg > cand_val_in);
            fsba_pkg::STRAT_NONE:  take = 1'b0;
            default:               take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_idx == IDX_W'(CELL_IDX))
            begin
                rem_reg <= wr_value;
            end
            found_reg <= cand_found_in || take;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= take ? IDX_W'(CELL_IDX) : cand_idx_in;
        val_reg <= take ? rem_reg : cand_val_in;
    end

    assign cand_found_out = found_reg;
    assign cand_idx_out   = idx_reg;
    assign cand_val_out   = val_reg;

endmodule
